[src/dot_printer_band_packer_assert.svh]
// Assertion macros for the dot printer band packer.
`ifndef DOT_PRINTER_BAND_PACKER_ASSERT_SVH
`define DOT_PRINTER_BAND_PACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DPBP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dpbp check failed");

`define DPBP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dpbp check failed");

`define DPBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dpbp check failed");

`else

`define DPBP_ASSERT_ALWAYS(lbl, expr)
`define DPBP_ASSERT_IMPL(lbl, ante, cons)
`define DPBP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/dpbp_pkg.sv]
// Types and constants shared by the band packer modules.
`timescale 1ns / 1ps
`default_nettype none

package dpbp_pkg;

    localparam int BAND_ROWS = 24;
    localparam int WORD_W    = 24;
    localparam int COLS_W    = 12;
    localparam int MARGIN_W  = 6;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 12;

    localparam logic [COLS_W-1:0] COLUMNS_RESET = 12'd1440;

    localparam logic [CFG_AW-1:0] CFG_DITHER  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MARGIN  = 2'd2;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_PULL  = 2'd2;

    localparam logic [2:0] PH_MARGIN = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_STAR   = 3'd2;
    localparam logic [2:0] PH_MODE   = 3'd3;
    localparam logic [2:0] PH_CLO    = 3'd4;
    localparam logic [2:0] PH_CHI    = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;
    localparam logic [2:0] PH_NL     = 3'd7;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_SET  = 2'd1;
    localparam logic [1:0] WR_CLR  = 2'd2;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_STAR  = 8'd42;
    localparam logic [7:0] BYTE_MODE  = 8'd39;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_NL    = 8'd10;

    localparam logic [WORD_W-1:0] TOP_ROW_BIT = 24'h800000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       band_last;
        logic       accepted;
        logic       draining;
    } t_result;

endpackage

`default_nettype wire

[src/dpbp_band_ram.sv]
// Band store: one-port-write, one-port-read memory with registered read and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module dpbp_band_ram #(
    parameter int DEPTH = 2048
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  wire                        i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire  [dpbp_pkg::WORD_W-1:0] i_wr_data,
    output logic [dpbp_pkg::WORD_W-1:0] o_rd_data
);
    import dpbp_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_q;
    logic [AW-1:0]     r_rd_addr;
    logic              r_fwd_vld;
    logic [AW-1:0]     r_fwd_addr;
    logic [WORD_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q    <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // last write is newer than anything the registered read could have seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = (r_fwd_vld && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_q;

endmodule

`default_nettype wire

[src/dot_printer_band_packer.sv]
// Top level: dot printer band packer, pixel to 24-row band store and byte stream out.
//
//  channel     dir  handshake                 payload
//  s_axis      in   s_axis_tvalid/tready      tuser=req_type, tdata=pixel,threshold
//  m_axis      out  m_axis_tvalid/tready      tuser=out_valid, tlast=band_last,
//                                             tdata=out_byte,accepted,draining
//  cfg         in   i_cfg_we                  i_cfg_addr, i_cfg_data
//
// One item per cycle unless m_axis stalls or the clearing pass runs; each item reads the band
// store; sets and clears write back from the store stage, a read-modify-write over two stages.
// A result goes via the store stage to the output register, taken when m_axis_tready is high.
// After reset a clearing pass writes every band store word; no items are taken meanwhile.
// Stalls on m_axis fill the output register and then the store stage before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "dot_printer_band_packer_assert.svh"

module dot_printer_band_packer #(
    parameter int MAX_COLUMNS = 2048
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire  [15:0]                 s_axis_tdata,  // pixel[7:0], dither_threshold[15:8]
    input  wire  [1:0]                  s_axis_tuser,  // req_type[1:0]
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // out_byte[7:0], accepted[8], draining[9]
    output logic                        m_axis_tuser,  // out_valid
    output logic                        m_axis_tlast,
    input  wire                         i_cfg_we,
    input  wire  [dpbp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire  [dpbp_pkg::CFG_DW-1:0] i_cfg_data
);
    import dpbp_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int WW = CW + 1;
    localparam int XW = (WW > COLS_W) ? WW : COLS_W;

    // configuration
    logic                r_dither;
    logic [COLS_W-1:0]   r_columns;
    logic [MARGIN_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither  <= 1'b0;
            r_columns <= COLUMNS_RESET;
            r_margin  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DITHER:  r_dither  <= i_cfg_data[0];
                CFG_COLUMNS: r_columns <= i_cfg_data[COLS_W-1:0];
                CFG_MARGIN:  r_margin  <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [XW-1:0] v_cols_x;
    logic [WW-1:0] v_width;
    logic [15:0]   v_width16;

    always_comb begin
        v_cols_x = XW'(r_columns);
        if (v_cols_x == '0) begin
            v_cols_x = XW'(1);
        end
        if (v_cols_x > XW'(MAX_COLUMNS)) begin
            v_cols_x = XW'(MAX_COLUMNS);
        end
        v_width   = v_cols_x[WW-1:0];
        v_width16 = 16'(v_width);
    end

    // clearing pass
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_COLUMNS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // fill and drain state
    logic [4:0]          r_row,   n_row;
    logic [CW-1:0]       r_fill,  n_fill;
    logic                r_drain, n_drain;
    logic [2:0]          r_phase, n_phase;
    logic [MARGIN_W-1:0] r_mcnt,  n_mcnt;
    logic [WW-1:0]       r_col,   n_col;
    logic [1:0]          r_k,     n_k;

    // store stage and output register
    logic              r_s1_v;
    t_result           r_s1_res;
    logic              r_s1_mem;
    logic [1:0]        r_s1_k;
    logic [1:0]        r_s1_wr;
    logic [CW-1:0]     r_s1_addr;
    logic [WORD_W-1:0] r_s1_mask;
    logic              r_out_v;
    t_result           r_out;

    logic              s_fire, s1_fire;
    t_result           v_res, v_s1_res;
    logic              v_mem, v_dot;
    logic [1:0]        v_k, v_wr;
    logic [CW-1:0]     v_addr;
    logic [WORD_W-1:0] v_mask, rd_data, wr_data;
    logic [2:0]        v_ph;
    logic              wr_en;
    logic [CW-1:0]     wr_addr;

    assign s1_fire       = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_v || s1_fire);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_row   = r_row;
        n_fill  = r_fill;
        n_drain = r_drain;
        n_phase = r_phase;
        n_mcnt  = r_mcnt;
        n_col   = r_col;
        n_k     = r_k;
        v_res   = '0;
        v_mem   = 1'b0;
        v_k     = r_k;
        v_wr    = WR_NONE;
        v_addr  = r_fill;
        v_mask  = TOP_ROW_BIT >> r_row;
        v_dot   = r_dither ? (s_axis_tdata[7:0] <= s_axis_tdata[15:8])
                           : (s_axis_tdata[7:0] == 8'd0);
        v_ph    = r_phase;
        case (s_axis_tuser)
            REQ_PIXEL: begin
                if (!r_drain) begin
                    v_res.accepted = 1'b1;
                    if (v_dot) begin
                        v_wr = WR_SET;
                    end
                    if (({1'b0, r_fill} + WW'(1)) >= v_width) begin
                        n_fill = '0;
                        if (r_row == 5'(BAND_ROWS - 1)) begin
                            n_row   = '0;
                            n_drain = 1'b1;
                            n_phase = PH_MARGIN;
                            n_mcnt  = '0;
                            n_col   = '0;
                            n_k     = '0;
                        end else begin
                            n_row = r_row + 5'd1;
                        end
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                end
            end
            REQ_FRAME: begin
                if (!r_drain) begin
                    v_res.accepted = 1'b1;
                    if (r_row != '0 || r_fill != '0) begin
                        n_row   = '0;
                        n_fill  = '0;
                        n_drain = 1'b1;
                        n_phase = PH_MARGIN;
                        n_mcnt  = '0;
                        n_col   = '0;
                        n_k     = '0;
                    end
                end
            end
            REQ_PULL: begin
                if (r_drain) begin
                    v_res.out_valid = 1'b1;
                    if (v_ph == PH_MARGIN && r_mcnt >= r_margin) begin
                        v_ph   = PH_ESC;
                        n_mcnt = '0;
                    end
                    if (v_ph == PH_DATA && r_col >= v_width) begin
                        v_ph = PH_NL;
                    end
                    n_phase = v_ph;
                    unique case (v_ph)
                        PH_MARGIN: begin
                            v_res.out_byte = BYTE_SPACE;
                            n_mcnt         = r_mcnt + MARGIN_W'(1);
                        end
                        PH_ESC: begin
                            v_res.out_byte = BYTE_ESC;
                            n_phase        = PH_STAR;
                        end
                        PH_STAR: begin
                            v_res.out_byte = BYTE_STAR;
                            n_phase        = PH_MODE;
                        end
                        PH_MODE: begin
                            v_res.out_byte = BYTE_MODE;
                            n_phase        = PH_CLO;
                        end
                        PH_CLO: begin
                            v_res.out_byte = v_width16[7:0];
                            n_phase        = PH_CHI;
                        end
                        PH_CHI: begin
                            v_res.out_byte = v_width16[15:8];
                            n_phase        = PH_DATA;
                            n_col          = '0;
                            n_k            = '0;
                        end
                        PH_DATA: begin
                            v_mem  = 1'b1;
                            v_addr = r_col[CW-1:0];
                            if (r_k == 2'd2) begin
                                v_wr  = WR_CLR;
                                n_col = r_col + WW'(1);
                                n_k   = '0;
                                if ((r_col + WW'(1)) >= v_width) begin
                                    n_phase = PH_NL;
                                end
                            end else begin
                                n_k = r_k + 2'd1;
                            end
                        end
                        PH_NL: begin
                            v_res.out_byte  = BYTE_NL;
                            v_res.band_last = 1'b1;
                            n_drain         = 1'b0;
                            n_phase         = PH_MARGIN;
                            n_mcnt          = '0;
                            n_col           = '0;
                            n_k             = '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        v_res.draining = n_drain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_phase <= PH_MARGIN;
            r_mcnt  <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else if (s_fire) begin
            r_row   <= n_row;
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_phase <= n_phase;
            r_mcnt  <= n_mcnt;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_fire) begin
            r_s1_v <= 1'b1;
        end else if (s1_fire) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_res  <= v_res;
            r_s1_mem  <= v_mem;
            r_s1_k    <= v_k;
            r_s1_wr   <= v_wr;
            r_s1_addr <= v_addr;
            r_s1_mask <= v_mask;
        end
    end

    dpbp_band_ram #(
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_fire),
        .i_rd_addr (v_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign wr_en   = r_clr_busy || (s1_fire && r_s1_wr != WR_NONE);
    assign wr_addr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign wr_data = (r_clr_busy || r_s1_wr == WR_CLR) ? '0 : (rd_data | r_s1_mask);

    always_comb begin
        v_s1_res = r_s1_res;
        if (r_s1_mem) begin
            case (r_s1_k)
                2'd0:    v_s1_res.out_byte = rd_data[23:16];
                2'd1:    v_s1_res.out_byte = rd_data[15:8];
                default: v_s1_res.out_byte = rd_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_fire) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= v_s1_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'd0, r_out.draining, r_out.accepted, r_out.out_byte};
    assign m_axis_tuser  = r_out.out_valid;
    assign m_axis_tlast  = r_out.band_last;

    `DPBP_ASSERT_IMPL(a_clr_blocks_input, r_clr_busy, !s_axis_tready)
    `DPBP_ASSERT_IMPL(a_nl_closes_band, r_out_v && r_out.band_last, r_out.out_valid && !r_out.draining)
    `DPBP_ASSERT_NEXT(a_s1_holds, r_s1_v && !s1_fire, r_s1_v && $stable(r_s1_addr))
    `DPBP_ASSERT_IMPL(a_write_only_from_s1, wr_en && !r_clr_busy, s1_fire)

endmodule

`default_nettype wire

[tb/tb_dot_printer_band_packer.sv]
`timescale 1ns / 1ps
// Testbench for the dot printer band packer: predicts every output item and checks it.

import dpbp_pkg::*;

localparam int MAX_COLS = 2048;

class band_byte_tracker;
    bit [WORD_W-1:0]   col_word [MAX_COLS];
    bit [4:0]          row_idx;
    int unsigned       fill_col;
    bit                drain_on;
    bit [2:0]          phase;
    int unsigned       byte_cnt;
    bit                dither_on;
    bit [COLS_W-1:0]   col_cfg;
    bit [MARGIN_W-1:0] margin_cfg;
    t_result           pending_bytes [$];
    int unsigned       errors;

    function new();
        foreach (col_word[i]) col_word[i] = '0;
        row_idx    = '0;
        fill_col   = 0;
        drain_on   = 1'b0;
        phase      = PH_MARGIN;
        byte_cnt   = 0;
        dither_on  = 1'b0;
        col_cfg    = COLUMNS_RESET;
        margin_cfg = '0;
        errors     = 0;
    endfunction

    function void set_reg(bit [CFG_AW-1:0] addr, bit [CFG_DW-1:0] data);
        case (addr)
            CFG_DITHER:  dither_on = data[0];
            CFG_COLUMNS: col_cfg = data;
            CFG_MARGIN:  margin_cfg = data[MARGIN_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned row_width();
        if (col_cfg == 0) return 1;
        if (col_cfg > MAX_COLS) return MAX_COLS;
        return col_cfg;
    endfunction

    function void start_band();
        drain_on = 1'b1;
        phase    = PH_MARGIN;
        byte_cnt = 0;
    endfunction

    function bit [7:0] next_byte(output bit last);
        int unsigned w;
        int unsigned col;
        int unsigned k;
        bit [WORD_W-1:0] word;
        bit [7:0] b;
        w    = row_width();
        b    = '0;
        last = 1'b0;
        if (phase == PH_MARGIN && byte_cnt >= margin_cfg) begin
            phase    = PH_ESC;
            byte_cnt = 0;
        end
        if (phase == PH_DATA && byte_cnt >= 3 * w) phase = PH_NL;
        case (phase)
            PH_MARGIN: begin
                b = BYTE_SPACE;
                byte_cnt++;
            end
            PH_ESC: begin
                b     = BYTE_ESC;
                phase = PH_STAR;
            end
            PH_STAR: begin
                b     = BYTE_STAR;
                phase = PH_MODE;
            end
            PH_MODE: begin
                b     = BYTE_MODE;
                phase = PH_CLO;
            end
            PH_CLO: begin
                b     = w[7:0];
                phase = PH_CHI;
            end
            PH_CHI: begin
                b        = w[15:8];
                phase    = PH_DATA;
                byte_cnt = 0;
            end
            PH_DATA: begin
                col = byte_cnt / 3;
                k   = byte_cnt % 3;
                if (col < MAX_COLS) begin
                    word = col_word[col] >> (16 - 8 * k);
                    b    = word[7:0];
                    if (k == 2) col_word[col] = '0;
                end
                byte_cnt++;
                if (byte_cnt >= 3 * w) phase = PH_NL;
            end
            default: begin
                b        = BYTE_NL;
                last     = 1'b1;
                drain_on = 1'b0;
                phase    = PH_MARGIN;
                byte_cnt = 0;
            end
        endcase
        return b;
    endfunction

    function void note_item(bit [1:0] req, bit [7:0] pix, bit [7:0] thr);
        t_result r;
        bit dot;
        bit last;
        r = '0;
        case (req)
            REQ_PIXEL: begin
                if (!drain_on) begin
                    dot = dither_on ? (pix <= thr) : (pix == 8'd0);
                    if (fill_col < MAX_COLS && dot) col_word[fill_col] |= TOP_ROW_BIT >> row_idx;
                    fill_col++;
                    if (fill_col >= row_width()) begin
                        fill_col = 0;
                        row_idx++;
                        if (row_idx >= BAND_ROWS) begin
                            row_idx = '0;
                            start_band();
                        end
                    end
                    r.accepted = 1'b1;
                end
            end
            REQ_FRAME: begin
                if (!drain_on) begin
                    r.accepted = 1'b1;
                    if (row_idx != 0 || fill_col != 0) begin
                        row_idx  = '0;
                        fill_col = 0;
                        start_band();
                    end
                end
            end
            REQ_PULL: begin
                if (drain_on) begin
                    r.out_byte  = next_byte(last);
                    r.out_valid = 1'b1;
                    r.band_last = last;
                end
            end
            default: ;
        endcase
        r.draining = drain_on;
        pending_bytes.push_back(r);
    endfunction

    function void check_result(t_result got, bit [5:0] pad);
        t_result want;
        if (pending_bytes.size() == 0) begin
            $error("output item with none expected: out_byte %0d", got.out_byte);
            errors++;
            return;
        end
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
            errors++;
        end
        if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0b, got %0b", want.out_valid, got.out_valid);
            errors++;
        end
        if (got.band_last !== want.band_last) begin
            $error("band_last: expected %0b, got %0b", want.band_last, got.band_last);
            errors++;
        end
        if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
            errors++;
        end
        if (got.draining !== want.draining) begin
            $error("draining: expected %0b, got %0b", want.draining, got.draining);
            errors++;
        end
        if (pad !== 6'd0) begin
            $error("tdata pad: expected 0, got %0h", pad);
            errors++;
        end
    endfunction
endclass

module tb_dot_printer_band_packer;

    localparam logic [1:0]        REQ_SPARE    = 2'd3;
    localparam logic [CFG_AW-1:0] CFG_SPARE    = 2'd3;
    localparam int                RANDOM_ITEMS = 580;
    localparam int                STALL_LIMIT  = 6000;
    localparam int                LONG_HOLD    = 120;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // pixel[7:0], dither_threshold[15:8]
    logic [1:0]        s_axis_tuser;   // req_type[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // out_byte[7:0], accepted[8], draining[9]
    logic              m_axis_tuser;   // out_valid
    logic              m_axis_tlast;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    band_byte_tracker band_pred = new();
    int unsigned      burst_left;
    int unsigned      idle_cycles;
    int unsigned      hold_reqs;

    dot_printer_band_packer #(.MAX_COLUMNS(MAX_COLS)) i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            band_pred.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            band_pred.check_result({m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
                                    m_axis_tdata[8], m_axis_tdata[9]}, m_axis_tdata[15:10]);
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: segments of random stall density, plus one long hold on request
    initial begin
        int unsigned seg_left;
        int unsigned stall_pct;
        int unsigned hold_left;
        int unsigned hold_seen;
        m_axis_tready = 1'b0;
        seg_left      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        hold_seen     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_left = LONG_HOLD;
                hold_seen = hold_reqs;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 200);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input bit [1:0] req, input bit [7:0] pix, input bit [7:0] thr);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {thr, pix};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (band_pred.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input bit [CFG_AW-1:0] addr, input bit [CFG_DW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        band_pred.set_reg(addr, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain_band();
        while (band_pred.drain_on) send_item(REQ_PULL, 8'($urandom), 8'($urandom));
    endtask

    task automatic random_setup();
        int unsigned roll;
        if ($urandom_range(0, 9) < 6) write_reg(CFG_DITHER, 12'($urandom));
        if ($urandom_range(0, 9) < 6) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      write_reg(CFG_COLUMNS, 12'($urandom_range(1, 6)));
            else if (roll < 80) write_reg(CFG_COLUMNS, 12'd0);
            else                write_reg(CFG_COLUMNS, 12'($urandom_range(7, 24)));
        end
        if ($urandom_range(0, 9) < 6) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      write_reg(CFG_MARGIN, {6'($urandom), 6'($urandom_range(0, 3))});
            else if (roll < 90) write_reg(CFG_MARGIN, {6'($urandom), 6'($urandom_range(4, 12))});
            else                write_reg(CFG_MARGIN, 12'($urandom));
        end
        if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 12'($urandom));
    endtask

    task automatic random_item(output bit live);
        int unsigned roll;
        bit [7:0] pix;
        bit [7:0] thr;
        roll = $urandom_range(0, 99);
        pix  = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
        thr  = 8'($urandom);
        if (band_pred.drain_on) begin
            live = (roll < 88);
            if (roll < 88)      send_item(REQ_PULL, pix, thr);
            else if (roll < 94) send_item(REQ_PIXEL, pix, thr);
            else if (roll < 97) send_item(REQ_FRAME, pix, thr);
            else                send_item(REQ_SPARE, pix, thr);
        end else begin
            live = (roll < 93);
            if (roll < 90)      send_item(REQ_PIXEL, pix, thr);
            else if (roll < 93) send_item(REQ_FRAME, pix, thr);
            else if (roll < 97) send_item(REQ_PULL, pix, thr);
            else                send_item(REQ_SPARE, pix, thr);
        end
    endtask

    initial begin
        int unsigned counted;
        int unsigned phase_items;
        int unsigned n;
        bit live;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        burst_left    = 0;
        hold_reqs     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // store clearing pass after reset
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);

        // reset settings: idle pull, unknown request, empty frame end, partial row
        send_item(REQ_PULL, 8'hFF, 8'hFF);
        send_item(REQ_SPARE, 8'hFF, 8'h00);
        send_item(REQ_FRAME, 8'h00, 8'hFF);
        send_item(REQ_PIXEL, 8'h00, 8'h00);
        send_item(REQ_PIXEL, 8'hFF, 8'hFF);
        send_item(REQ_PIXEL, 8'h01, 8'h00);
        send_item(REQ_PIXEL, 8'h00, 8'hFF);
        send_item(REQ_FRAME, 8'h00, 8'h00);
        send_item(REQ_PIXEL, 8'h00, 8'h00);
        send_item(REQ_FRAME, 8'h00, 8'h00);
        send_item(REQ_SPARE, 8'h00, 8'h00);
        repeat (6) send_item(REQ_PULL, 8'h00, 8'h00);
        settle();
        write_reg(CFG_COLUMNS, 12'd4);
        drain_band();
        send_item(REQ_PULL, 8'h00, 8'h00);
        settle();

        // dither, zero columns, widest margin: one full band
        write_reg(CFG_DITHER, 12'h001);
        write_reg(CFG_COLUMNS, 12'd0);
        write_reg(CFG_MARGIN, 12'hFFF);
        for (int i = 0; i < BAND_ROWS; i++) begin
            case (i % 4)
                0:       send_item(REQ_PIXEL, 8'd0, 8'd0);
                1:       send_item(REQ_PIXEL, 8'd255, 8'd254);
                2:       send_item(REQ_PIXEL, 8'd255, 8'd255);
                default: send_item(REQ_PIXEL, 8'd128, 8'd127);
            endcase
        end
        drain_band();
        settle();

        // widest rows, including a width above the maximum; narrowed after the header
        write_reg(CFG_DITHER, 12'h000);
        write_reg(CFG_MARGIN, 12'h000);
        for (int i = 0; i < 2; i++) begin
            write_reg(CFG_COLUMNS, (i == 0) ? 12'd2048 : 12'd4095);
            send_item(REQ_PIXEL, 8'd0, 8'd0);
            send_item(REQ_PIXEL, 8'd7, 8'd0);
            send_item(REQ_PIXEL, 8'd0, 8'd0);
            send_item(REQ_FRAME, 8'd0, 8'd0);
            repeat (6) send_item(REQ_PULL, 8'd0, 8'd0);
            settle();
            write_reg(CFG_COLUMNS, 12'd3);
            drain_band();
            settle();
        end

        // width shrinks mid-row, then mid-band
        write_reg(CFG_COLUMNS, 12'd5);
        write_reg(CFG_MARGIN, 12'd2);
        repeat (3) send_item(REQ_PIXEL, 8'd0, 8'd0);
        settle();
        write_reg(CFG_COLUMNS, 12'd2);
        while (!band_pred.drain_on)
            send_item(REQ_PIXEL, $urandom_range(0, 1) ? 8'd0 : 8'($urandom), 8'($urandom));
        repeat (10) send_item(REQ_PULL, 8'd0, 8'd0);
        settle();
        write_reg(CFG_COLUMNS, 12'd1);
        drain_band();
        settle();

        counted = 0;
        n       = 0;
        while (counted < RANDOM_ITEMS) begin
            random_setup();
            phase_items = $urandom_range(20, 150);
            if (n == 2) begin
                phase_items = 150;
                hold_reqs++;
            end
            repeat (phase_items) begin
                random_item(live);
                if (live) counted++;
            end
            settle();
            n++;
        end
        repeat (10) @(posedge i_clk);

        if (band_pred.errors == 0 && band_pred.pending_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
